// ===== rtl/core/bdq_pkg.sv =====
package bdq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int DATA_W       = 32;
  localparam int CMD_W        = 3;
  localparam int STAT_W       = 2;
  localparam int POS_W        = 5;
  localparam int RESULT_LIMIT = 16;

  // Stream payload widths, padded to whole bytes.
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LIST      = 3'd5;

  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

endpackage

// ===== rtl/core/bdq_ram.sv =====
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bounded_deque_with_search_unit.sv =====
// Channel   Dir  Handshake                    Payload (lowest bit first)
// s_axis    in   s_axis_tvalid_i/tready_o     tdata: cmd[2:0], value[34:3], zero pad
// m_axis    out  m_axis_tvalid_o/tready_i     tdata: status[1:0], position[6:2],
//                                             element[38:7], zero pad; tlast: last
//
// Inserts, removes and commands on an empty store each give one result beat;
// unused commands give none. The beat sits in the output register from the next cycle.
// A search reads from the front and stops at the first match or at the last element;
// a list gives one beat per element, at most RESULT_LIMIT, one store read a cycle
// through the RAM port while the output is not stalled. A stalled output beat holds
// the walk; no new beat is accepted until the walk ends. Reset clears the front index,
// the occupancy and the control state; store contents are left as they are.
module bounded_deque_with_search_unit #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [bdq_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // cmd, value, pad
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [bdq_pkg::M_TDATA_W-1:0] m_axis_tdata_o,  // status, position, element, pad
  output logic                          m_axis_tlast_o
);

  import bdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic state_q, state_d;
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] lim_q, lim_d;
  logic walk_list_q, walk_list_d;
  logic [DATA_W-1:0] val_q, val_d;

  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;
  logic [DATA_W-1:0] out_elem_q, out_elem_d;
  logic              out_last_q, out_last_d;

  logic [CMD_W-1:0]  in_cmd;
  logic [DATA_W-1:0] in_value;
  logic              can_go;
  logic              s_acc;
  logic              full, empty;
  logic [AW-1:0]     front_dec, front_inc;
  logic [AW-1:0]     slot_off;
  logic [AW:0]       slot_sum;
  logic [AW-1:0]     slot_addr;
  logic [CW-1:0]     idx_p1;
  logic              last_hit;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              emit;
  logic [STAT_W-1:0] e_status;
  logic [POS_W-1:0]  e_pos;
  logic [DATA_W-1:0] e_elem;
  logic              e_last;

  assign in_cmd   = s_axis_tdata_i[CMD_W-1:0];
  assign in_value = s_axis_tdata_i[CMD_W+DATA_W-1:CMD_W];

  assign can_go          = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && can_go;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  assign full  = (occ_q == CW'(DEPTH));
  assign empty = (occ_q == '0);

  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

  assign idx_p1   = CW'(idx_q) + CW'(1);
  assign last_hit = (idx_p1 == lim_q);

  // One ring adder serves the walk reads, including the first read at the front, and the back insert.
  always_comb begin
    if (state_q == ST_WALK) begin
      slot_off = idx_q + AW'(1);
    end else if (in_cmd == CMD_INS_BACK) begin
      slot_off = occ_q[AW-1:0];
    end else begin
      slot_off = '0;
    end
    slot_sum = {1'b0, front_q} + {1'b0, slot_off};
    if (slot_sum >= (AW+1)'(DEPTH)) begin
      slot_addr = AW'(slot_sum - (AW+1)'(DEPTH));
    end else begin
      slot_addr = slot_sum[AW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    occ_d       = occ_q;
    idx_d       = idx_q;
    lim_d       = lim_q;
    walk_list_d = walk_list_q;
    val_d       = val_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = slot_addr;
    emit        = 1'b0;
    e_status    = STAT_DONE;
    e_pos       = '0;
    e_elem      = '0;
    e_last      = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          unique case (in_cmd)
            CMD_INS_FRONT: begin
              emit = 1'b1;
              if (full) begin
                e_status = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_dec;
                front_d   = front_dec;
                occ_d     = occ_q + CW'(1);
              end
            end
            CMD_INS_BACK: begin
              emit = 1'b1;
              if (full) begin
                e_status = STAT_FULL;
              end else begin
                ram_we = 1'b1;
                occ_d  = occ_q + CW'(1);
              end
            end
            CMD_REM_FRONT: begin
              emit = 1'b1;
              if (empty) begin
                e_status = STAT_EMPTY;
              end else begin
                front_d = front_inc;
                occ_d   = occ_q - CW'(1);
              end
            end
            CMD_REM_BACK: begin
              emit = 1'b1;
              if (empty) begin
                e_status = STAT_EMPTY;
              end else begin
                occ_d = occ_q - CW'(1);
              end
            end
            CMD_SEARCH, CMD_LIST: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = STAT_EMPTY;
              end else begin
                ram_re      = 1'b1;
                idx_d       = '0;
                walk_list_d = (in_cmd == CMD_LIST);
                val_d       = in_value;
                state_d     = ST_WALK;
                if ((in_cmd == CMD_LIST) && (int'(occ_q) > RESULT_LIMIT)) begin
                  lim_d = CW'(RESULT_LIMIT);
                end else begin
                  lim_d = occ_q;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        // The read data always belongs to the element at offset idx_q.
        if (can_go) begin
          if (walk_list_q) begin
            emit   = 1'b1;
            e_pos  = POS_W'(idx_p1);
            e_elem = ram_rdata;
            e_last = last_hit;
            if (last_hit) begin
              state_d = ST_IDLE;
            end else begin
              ram_re = 1'b1;
              idx_d  = idx_q + AW'(1);
            end
          end else if (ram_rdata == val_q) begin
            emit    = 1'b1;
            e_pos   = POS_W'(idx_p1);
            state_d = ST_IDLE;
          end else if (last_hit) begin
            emit     = 1'b1;
            e_status = STAT_NOT_FOUND;
            state_d  = ST_IDLE;
          end else begin
            ram_re = 1'b1;
            idx_d  = idx_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_elem_d   = out_elem_q;
    out_last_d   = out_last_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_status_d = e_status;
      out_pos_d    = e_pos;
      out_elem_d   = e_elem;
      out_last_d   = e_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    lim_q        <= lim_d;
    walk_list_q  <= walk_list_d;
    val_q        <= val_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_elem_q   <= out_elem_d;
    out_last_q   <= out_last_d;
  end

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_value),
    .re_i    (ram_re),
    .raddr_i (slot_addr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - STAT_W - POS_W - DATA_W){1'b0}},
                            out_elem_q, out_pos_q, out_status_q};

  a_occ_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(DEPTH))
    else $error("occupancy exceeds the store depth");

  a_front_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= AW'(DEPTH - 1))
    else $error("front index outside the ring");

  a_no_write_in_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (!ram_we && occ_q == $past(occ_q)))
    else $error("store changed while a walk is in progress");

  a_walk_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (CW'(idx_q) < lim_q))
    else $error("walk index beyond its limit");

  a_walk_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !empty && (in_cmd == CMD_SEARCH || in_cmd == CMD_LIST))
      |=> (state_q == ST_WALK && !out_valid_q || state_q == ST_WALK))
    else $error("walk did not start after a search or list beat");

endmodule
